/* hw/rtl/ccns_pkg.sv */
// ccns_pkg: types, constants and the month length table for the
// one-second calendar clock advance. No dependencies.

package ccns_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOURS_W  = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // time and date limits
    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [HOURS_W-1:0]  HOUR_LAST   = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]    FEB_LEAP_DAYS = 5'd29;
    localparam logic [YEAR_W-1:0]   YEAR_LAST   = 14'd9999;

    // remainder by 25 through a reciprocal: floor(y * 5243 / 2^17) = y / 25
    // holds for every 14-bit year
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
    localparam logic [YEAR_W-1:0]  DIV_25   = 14'd25;

    // days per month, indexed by month number; unused codes read as 31
    localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    // item after the time carry stage
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOURS_W-1:0]  hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
        logic                rolled;
        logic                err;
        logic [PROD_W-1:0]   prod;
    } t_time_item;

    // item after the month length stage
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOURS_W-1:0]  hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
        logic                rolled;
        logic                err;
        logic                last_day;
    } t_len_item;

    // finished result
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOURS_W-1:0]  hours;
        logic [MINUTE_W-1:0] minutes;
        logic [SECOND_W-1:0] seconds;
        logic                rolled;
        logic                err;
    } t_result;

endpackage

/* hw/rtl/calendar_clock_next_second_unit.sv */
// calendar_clock_next_second_unit: top level of the one-second calendar
// clock advance. Uses ccns_pkg, ccns_time_stage, ccns_len_stage and
// ccns_date_stage.
//
// Usage:
//   Input channel: i_valid with the six date and time fields; a request is
//   taken at a rising edge where i_valid is high and o_stall is low.
//   Output channel: o_valid with the result fields; a request leaves at a
//   rising edge where o_valid is high and i_stall is low.
//   Stages in order: time carry and year product, leap test and month
//   length, then the date advance into the output register. Throughput
//   is one request per cycle while i_stall is low; each stage register
//   loads whenever it is empty or its successor moves, so bubbles close up.
//   When the receiver stalls, the result holds on the outputs and the
//   stages behind it keep filling; o_stall rises only once all three
//   stages hold a request.
//   A month outside 1..12 or a day of zero sets o_input_error and passes
//   the fields through unchanged.
//   Reset (synchronous, active low) empties the pipeline; nothing else
//   needs clearing.

module calendar_clock_next_second_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ccns_pkg::YEAR_W-1:0]     i_year_in,
    input  logic [ccns_pkg::MONTH_W-1:0]    i_month_in,
    input  logic [ccns_pkg::DAY_W-1:0]      i_day_in,
    input  logic [ccns_pkg::HOURS_W-1:0]    i_hours_in,
    input  logic [ccns_pkg::MINUTE_W-1:0]   i_minutes_in,
    input  logic [ccns_pkg::SECOND_W-1:0]   i_seconds_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ccns_pkg::YEAR_W-1:0]     o_year_out,
    output logic [ccns_pkg::MONTH_W-1:0]    o_month_out,
    output logic [ccns_pkg::DAY_W-1:0]      o_day_out,
    output logic [ccns_pkg::HOURS_W-1:0]    o_hours_out,
    output logic [ccns_pkg::MINUTE_W-1:0]   o_minutes_out,
    output logic [ccns_pkg::SECOND_W-1:0]   o_seconds_out,
    output logic                            o_day_rolled,
    output logic                            o_input_error
);

    logic                 time_ready;
    logic                 time_valid;
    ccns_pkg::t_time_item time_item;
    logic                 len_ready;
    logic                 len_valid;
    ccns_pkg::t_len_item  len_item;
    logic                 date_ready;
    ccns_pkg::t_result    result;

    // stage one: validity and time carry
    ccns_time_stage u_time (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (time_ready),
        .i_year    (i_year_in),
        .i_month   (i_month_in),
        .i_day     (i_day_in),
        .i_hours   (i_hours_in),
        .i_minutes (i_minutes_in),
        .i_seconds (i_seconds_in),
        .o_valid   (time_valid),
        .i_ready   (len_ready),
        .o_item    (time_item)
    );

    // stage two: leap year and month length
    ccns_len_stage u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (time_valid),
        .o_ready (len_ready),
        .i_item  (time_item),
        .o_valid (len_valid),
        .i_ready (date_ready),
        .o_item  (len_item)
    );

    // stage three: date advance and output register
    ccns_date_stage u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (len_valid),
        .o_ready (date_ready),
        .i_item  (len_item),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_item  (result)
    );

    assign o_stall       = !time_ready;
    assign o_year_out    = result.year;
    assign o_month_out   = result.month;
    assign o_day_out     = result.day;
    assign o_hours_out   = result.hours;
    assign o_minutes_out = result.minutes;
    assign o_seconds_out = result.seconds;
    assign o_day_rolled  = result.rolled;
    assign o_input_error = result.err;

endmodule

/* hw/rtl/ccns_time_stage.sv */
// ccns_time_stage: first pipeline stage; checks month and day, carries the
// time of day and starts the year remainder product. Uses ccns_pkg.

module ccns_time_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ccns_pkg::YEAR_W-1:0]     i_year,
    input  logic [ccns_pkg::MONTH_W-1:0]    i_month,
    input  logic [ccns_pkg::DAY_W-1:0]      i_day,
    input  logic [ccns_pkg::HOURS_W-1:0]    i_hours,
    input  logic [ccns_pkg::MINUTE_W-1:0]   i_minutes,
    input  logic [ccns_pkg::SECOND_W-1:0]   i_seconds,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ccns_pkg::t_time_item            o_item
);

    logic                 r_valid;
    ccns_pkg::t_time_item r_item;
    ccns_pkg::t_time_item n_item;
    logic                 carry_sec;
    logic                 carry_min;
    logic                 carry_hour;

    assign o_ready = !r_valid || i_ready;

    // validity check and time carry chain
    always_comb begin
        carry_sec  = i_seconds >= ccns_pkg::SECOND_LAST;
        carry_min  = carry_sec && (i_minutes >= ccns_pkg::MINUTE_LAST);
        carry_hour = carry_min && (i_hours >= ccns_pkg::HOUR_LAST);

        n_item.year    = i_year;
        n_item.month   = i_month;
        n_item.day     = i_day;
        n_item.err     = (i_month < ccns_pkg::MONTH_FIRST) ||
                         (i_month > ccns_pkg::MONTH_LAST) ||
                         (i_day == '0);
        n_item.prod    = ccns_pkg::PROD_W'(i_year) * ccns_pkg::PROD_W'(ccns_pkg::RECIP_25);
        n_item.hours   = i_hours;
        n_item.minutes = i_minutes;
        n_item.seconds = i_seconds;
        n_item.rolled  = 1'b0;

        if (!n_item.err) begin
            n_item.seconds = carry_sec ? '0 : i_seconds + 1'b1;
            if (carry_sec) begin
                n_item.minutes = carry_min ? '0 : i_minutes + 1'b1;
            end
            if (carry_min) begin
                n_item.hours = carry_hour ? '0 : i_hours + 1'b1;
            end
            n_item.rolled = carry_hour;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/ccns_len_stage.sv */
// ccns_len_stage: second pipeline stage; finishes the leap year test and
// finds whether the day is the last of its month. Uses ccns_pkg.

module ccns_len_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ccns_pkg::t_time_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ccns_pkg::t_len_item  o_item
);

    logic                            r_valid;
    ccns_pkg::t_len_item             r_item;
    ccns_pkg::t_len_item             n_item;
    logic [ccns_pkg::QUOT_W-1:0]     quot_25;
    logic [ccns_pkg::YEAR_W-1:0]     rem_25;
    logic                            leap;
    logic [ccns_pkg::DAY_W-1:0]      month_len;

    assign o_ready = !r_valid || i_ready;

    // leap year: by 4 and not by 100, or by 400 (100 = 4 * 25, 400 = 16 * 25)
    always_comb begin
        quot_25 = i_item.prod[ccns_pkg::PROD_W-1:ccns_pkg::RECIP_SHIFT];
        rem_25  = i_item.year -
                  ccns_pkg::YEAR_W'(ccns_pkg::YEAR_W'(quot_25) * ccns_pkg::DIV_25);
        leap    = ((i_item.year[1:0] == '0) && (rem_25 != '0)) ||
                  ((i_item.year[3:0] == '0) && (rem_25 == '0));

        month_len = ccns_pkg::MONTH_DAYS[i_item.month];
        if (i_item.month == ccns_pkg::MONTH_FEB && leap) begin
            month_len = ccns_pkg::FEB_LEAP_DAYS;
        end

        n_item.year     = i_item.year;
        n_item.month    = i_item.month;
        n_item.day      = i_item.day;
        n_item.hours    = i_item.hours;
        n_item.minutes  = i_item.minutes;
        n_item.seconds  = i_item.seconds;
        n_item.rolled   = i_item.rolled;
        n_item.err      = i_item.err;
        n_item.last_day = i_item.day >= month_len;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/ccns_date_stage.sv */
// ccns_date_stage: last pipeline stage and output register; advances day,
// month and year after a midnight wrap. Uses ccns_pkg.

module ccns_date_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ccns_pkg::t_len_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ccns_pkg::t_result   o_item
);

    logic              r_valid;
    ccns_pkg::t_result r_item;
    ccns_pkg::t_result n_item;

    assign o_ready = !r_valid || i_ready;

    // date advance on a midnight wrap
    always_comb begin
        n_item.year    = i_item.year;
        n_item.month   = i_item.month;
        n_item.day     = i_item.day;
        n_item.hours   = i_item.hours;
        n_item.minutes = i_item.minutes;
        n_item.seconds = i_item.seconds;
        n_item.rolled  = i_item.rolled;
        n_item.err     = i_item.err;

        if (i_item.rolled) begin
            if (!i_item.last_day) begin
                n_item.day = i_item.day + 1'b1;
            end else begin
                n_item.day = ccns_pkg::DAY_FIRST;
                if (i_item.month == ccns_pkg::MONTH_LAST) begin
                    n_item.month = ccns_pkg::MONTH_FIRST;
                    n_item.year  = (i_item.year >= ccns_pkg::YEAR_LAST) ?
                                   '0 : i_item.year + 1'b1;
                end else begin
                    n_item.month = i_item.month + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/ccns_checker.sv */
// ccns_checker: port-level assertions for calendar_clock_next_second_unit,
// attached by the bind at the end of this file. Uses ccns_pkg.

module ccns_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic [ccns_pkg::YEAR_W-1:0]     i_year_in,
    input  logic [ccns_pkg::MONTH_W-1:0]    i_month_in,
    input  logic [ccns_pkg::DAY_W-1:0]      i_day_in,
    input  logic [ccns_pkg::HOURS_W-1:0]    i_hours_in,
    input  logic [ccns_pkg::MINUTE_W-1:0]   i_minutes_in,
    input  logic [ccns_pkg::SECOND_W-1:0]   i_seconds_in,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [ccns_pkg::YEAR_W-1:0]     o_year_out,
    input  logic [ccns_pkg::MONTH_W-1:0]    o_month_out,
    input  logic [ccns_pkg::DAY_W-1:0]      o_day_out,
    input  logic [ccns_pkg::HOURS_W-1:0]    o_hours_out,
    input  logic [ccns_pkg::MINUTE_W-1:0]   o_minutes_out,
    input  logic [ccns_pkg::SECOND_W-1:0]   o_seconds_out,
    input  logic                            o_day_rolled,
    input  logic                            o_input_error
);

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a rejected request never rolls the date
    a_err_no_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_input_error |-> !o_day_rolled)
        else $error("date rolled on a rejected request");

    // a date roll lands on midnight of a valid first-or-later day
    a_roll_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_day_rolled |->
            (o_hours_out == '0) && (o_minutes_out == '0) &&
            (o_seconds_out == '0) && (o_day_out != '0))
        else $error("date rolled away from midnight");

    // accepted requests always leave with a month in range
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_input_error |->
            (o_month_out >= ccns_pkg::MONTH_FIRST) &&
            (o_month_out <= ccns_pkg::MONTH_LAST))
        else $error("month out of range on an accepted request");

endmodule

bind calendar_clock_next_second_unit ccns_checker u_ccns_checker (.*);
